[design/swept_box_collision_time_unit_assert.svh]
// Assertion macros for the swept box collision time unit.
`ifndef SWEPT_BOX_COLLISION_TIME_UNIT_ASSERT_SVH
`define SWEPT_BOX_COLLISION_TIME_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define SBCT_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

[design/sbct_pkg.sv]
// Types and constants shared by the swept box collision time design.
package sbct_pkg;

  // Fraction bits of the coordinate format
  localparam int COORD_FRAC = 16;

  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  // Per-request flags carried alongside the dividers
  typedef struct packed {
    logic rej;
    logic xz;
    logic yz;
    logic xpos;
    logic ypos;
  } side_t;

endpackage

[design/swept_box_collision_time_unit.sv]
// Top level of the swept box collision time unit.
// Usage: raise start with a moving box, a static box and a move on the in_ ports;
// the request is taken at any clock edge where start is high and busy is low.
// busy stays low, so a new request may be given in every cycle.
// Each request yields exactly one result on the out_ ports, marked by out_valid
// for a single cycle: out_hit, out_entry_time (1.0 = 1 << TIME_FRAC_BITS) and
// the unit normal of the later-entering axis. Results leave in request order.
// The four pipelined dividers have a dividend width of min(COORD_WIDTH + 1, 64)
// + 16. Throughput: one request per cycle, set by the dividers, which retire one
// quotient bit per pipeline stage.
// Reset clears every valid bit; requests in flight are dropped and no result
// appears until new requests have passed through.
// The receiver cannot stall: a result is shown once and must be taken then.
module swept_box_collision_time_unit #(
  parameter int COORD_WIDTH    = 32,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_moving_left,
  input  logic signed [COORD_WIDTH-1:0] in_moving_top,
  input  logic signed [COORD_WIDTH-1:0] in_moving_right,
  input  logic signed [COORD_WIDTH-1:0] in_moving_bottom,
  input  logic signed [COORD_WIDTH-1:0] in_static_left,
  input  logic signed [COORD_WIDTH-1:0] in_static_top,
  input  logic signed [COORD_WIDTH-1:0] in_static_right,
  input  logic signed [COORD_WIDTH-1:0] in_static_bottom,
  input  logic signed [COORD_WIDTH-1:0] in_move_x,
  input  logic signed [COORD_WIDTH-1:0] in_move_y,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [TIME_FRAC_BITS:0]       out_entry_time,
  output logic signed [1:0]             out_normal_x,
  output logic signed [1:0]             out_normal_y
);

  `include "swept_box_collision_time_unit_assert.svh"

  localparam int W         = COORD_WIDTH;
  localparam int DW        = (W + 1 > 64) ? 64 : W + 1;
  localparam int F         = sbct_pkg::COORD_FRAC;
  localparam int NW        = DW + F;
  localparam int DIV_LAT   = NW + 2;
  localparam int TOTAL_LAT = NW + 6;
  localparam int EW        = W + 2;
  localparam int SW        = F + TIME_FRAC_BITS + 1;
  localparam logic signed [EW-1:0] ONE = EW'(1) << F;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [W:0] v);
    logic signed [DW-1:0] r;
    if (DW == W + 1) begin
      r = DW'(v);
    end else if (v[W] != v[W-1]) begin
      r = v[W] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // Input register
  logic                v0_r;
  logic signed [W-1:0] ml_r, mt_r, mr_r, mb_r, sl_r, st_r, sr_r, sb_r, dx_r, dy_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ml_r <= in_moving_left;
      mt_r <= in_moving_top;
      mr_r <= in_moving_right;
      mb_r <= in_moving_bottom;
      sl_r <= in_static_left;
      st_r <= in_static_top;
      sr_r <= in_static_right;
      sb_r <= in_static_bottom;
      dx_r <= in_move_x;
      dy_r <= in_move_y;
    end
  end

  // Broad phase and edge distances
  logic signed [DW-1:0] bl, br, bt, bb, d_sl_mr, d_sr_ml, d_sb_mt, d_st_mb;
  logic                 xz, yz, xpos, ypos, overlap;
  sbct_pkg::side_t      side_nxt;

  assign xz   = dx_r == '0;
  assign yz   = dy_r == '0;
  assign xpos = !dx_r[W-1] && !xz;
  assign ypos = !dy_r[W-1] && !yz;

  assign bl = xpos ? DW'(ml_r) : sat_dw((W+1)'(ml_r) + (W+1)'(dx_r));
  assign br = xpos ? sat_dw((W+1)'(mr_r) + (W+1)'(dx_r)) : DW'(mr_r);
  assign bt = ypos ? sat_dw((W+1)'(mt_r) + (W+1)'(dy_r)) : DW'(mt_r);
  assign bb = ypos ? DW'(mb_r) : sat_dw((W+1)'(mb_r) + (W+1)'(dy_r));

  assign overlap = (bl < DW'(sr_r)) && (br > DW'(sl_r)) &&
                   (bb < DW'(st_r)) && (bt > DW'(sb_r));

  assign d_sl_mr = sat_dw((W+1)'(sl_r) - (W+1)'(mr_r));
  assign d_sr_ml = sat_dw((W+1)'(sr_r) - (W+1)'(ml_r));
  assign d_sb_mt = sat_dw((W+1)'(sb_r) - (W+1)'(mt_r));
  assign d_st_mb = sat_dw((W+1)'(st_r) - (W+1)'(mb_r));

  always_comb begin
    side_nxt      = '0;
    side_nxt.rej  = !overlap || (xz && yz);
    side_nxt.xz   = xz;
    side_nxt.yz   = yz;
    side_nxt.xpos = xpos;
    side_nxt.ypos = ypos;
  end

  logic                 va_r;
  sbct_pkg::side_t      side_a_r;
  logic signed [DW-1:0] ex_r, xx_r, ey_r, xy_r;
  logic signed [W-1:0]  dxa_r, dya_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    side_a_r <= side_nxt;
    ex_r     <= xpos ? d_sl_mr : d_sr_ml;
    xx_r     <= xpos ? d_sr_ml : d_sl_mr;
    ey_r     <= ypos ? d_sb_mt : d_st_mb;
    xy_r     <= ypos ? d_st_mb : d_sb_mt;
    dxa_r    <= dx_r;
    dya_r    <= dy_r;
  end

  // Time dividers
  logic                div_valid;
  logic signed [W-1:0] txe, txx, tye, tyx;

  sbct_div #(.NUM_WIDTH(DW), .DEN_WIDTH(W), .FRAC_BITS(F)) u_div_txe (
    .clk(clk), .rst_n(rst_n), .i_valid(va_r), .i_num(ex_r), .i_den(dxa_r),
    .o_valid(div_valid), .o_quot(txe)
  );
  sbct_div #(.NUM_WIDTH(DW), .DEN_WIDTH(W), .FRAC_BITS(F)) u_div_txx (
    .clk(clk), .rst_n(rst_n), .i_valid(va_r), .i_num(xx_r), .i_den(dxa_r),
    .o_valid(), .o_quot(txx)
  );
  sbct_div #(.NUM_WIDTH(DW), .DEN_WIDTH(W), .FRAC_BITS(F)) u_div_tye (
    .clk(clk), .rst_n(rst_n), .i_valid(va_r), .i_num(ey_r), .i_den(dya_r),
    .o_valid(), .o_quot(tye)
  );
  sbct_div #(.NUM_WIDTH(DW), .DEN_WIDTH(W), .FRAC_BITS(F)) u_div_tyx (
    .clk(clk), .rst_n(rst_n), .i_valid(va_r), .i_num(xy_r), .i_den(dya_r),
    .o_valid(), .o_quot(tyx)
  );

  // Flags travel beside the dividers
  sbct_pkg::side_t side_dly_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    side_dly_r[0] <= side_a_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  // Entry and exit selection
  sbct_pkg::side_t      sd;
  logic signed [EW-1:0] txe_e, txx_e, tye_e, tyx_e, te_nxt, tx_nxt;
  logic                 gt_nxt, rej1_nxt;

  assign sd    = side_dly_r[DIV_LAT-1];
  assign txe_e = EW'(txe);
  assign txx_e = EW'(txx);
  assign tye_e = EW'(tye);
  assign tyx_e = EW'(tyx);

  always_comb begin
    rej1_nxt = sd.rej ||
               ((sd.xz || txe_e < 0) && (sd.yz || tye_e < 0)) ||
               (!sd.xz && txe_e > ONE) || (!sd.yz && tye_e > ONE);
    gt_nxt   = !sd.xz && (sd.yz || txe_e > tye_e);
    te_nxt   = gt_nxt ? txe_e : tye_e;
    if (sd.xz) begin
      tx_nxt = tyx_e;
    end else if (sd.yz) begin
      tx_nxt = txx_e;
    end else begin
      tx_nxt = (txx_e < tyx_e) ? txx_e : tyx_e;
    end
  end

  logic                 v1_r, rej1_r, gt1_r, xpos1_r, ypos1_r;
  logic signed [EW-1:0] te1_r, tx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    rej1_r  <= rej1_nxt;
    gt1_r   <= gt_nxt;
    te1_r   <= te_nxt;
    tx1_r   <= tx_nxt;
    xpos1_r <= sd.xpos;
    ypos1_r <= sd.ypos;
  end

  // Final decision and time scaling
  logic                      hit_nxt;
  logic [SW-1:0]             t_scaled;
  logic                      out_valid_r, out_hit_r;
  logic [TIME_FRAC_BITS:0]   out_time_r;
  logic signed [1:0]         out_nx_r, out_ny_r;

  assign hit_nxt  = !rej1_r && !(te1_r > tx1_r);
  assign t_scaled = (SW'(te1_r[F:0]) << TIME_FRAC_BITS) >> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r  <= hit_nxt;
    out_time_r <= hit_nxt ? t_scaled[TIME_FRAC_BITS:0] : '0;
    out_nx_r   <= (hit_nxt && gt1_r)
                  ? (xpos1_r ? sbct_pkg::NORM_NEG : sbct_pkg::NORM_POS)
                  : sbct_pkg::NORM_ZERO;
    out_ny_r   <= (hit_nxt && !gt1_r)
                  ? (ypos1_r ? sbct_pkg::NORM_NEG : sbct_pkg::NORM_POS)
                  : sbct_pkg::NORM_ZERO;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_entry_time = out_time_r;
  assign out_normal_x   = out_nx_r;
  assign out_normal_y   = out_ny_r;

  `SBCT_ASSERT_DELAY(a_fixed_latency, start && !busy, TOTAL_LAT, out_valid,
                     "request did not produce a result at the fixed latency")
  `SBCT_ASSERT_NOW(a_miss_clean, out_valid && !out_hit,
                   out_entry_time == '0 && out_normal_x == sbct_pkg::NORM_ZERO &&
                   out_normal_y == sbct_pkg::NORM_ZERO,
                   "miss carries a nonzero time or normal")
  `SBCT_ASSERT_NOW(a_one_normal, out_valid && out_hit,
                   (out_normal_x != sbct_pkg::NORM_ZERO) !=
                   (out_normal_y != sbct_pkg::NORM_ZERO),
                   "hit must carry exactly one normal axis")
  `SBCT_ASSERT_NOW(a_time_range, out_valid && out_hit,
                   out_entry_time <= ((TIME_FRAC_BITS+1)'(1) << TIME_FRAC_BITS),
                   "entry time above one")

endmodule

[design/sbct_div.sv]
// Pipelined restoring divider: num * 2^FRAC_BITS / den, truncated and saturated.
module sbct_div #(
  parameter int NUM_WIDTH = 33,
  parameter int DEN_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        i_valid,
  input  logic signed [NUM_WIDTH-1:0] i_num,
  input  logic signed [DEN_WIDTH-1:0] i_den,
  output logic                        o_valid,
  output logic signed [DEN_WIDTH-1:0] o_quot
);

  localparam int NW = NUM_WIDTH + FRAC_BITS;

  logic                 v_r   [0:NW];
  logic [NW-1:0]        a_r   [0:NW];
  logic [NW-1:0]        q_r   [0:NW];
  logic [DEN_WIDTH-1:0] rem_r [0:NW];
  logic [DEN_WIDTH-1:0] den_r [0:NW];
  logic                 neg_r [0:NW];

  logic                        out_valid_r;
  logic signed [DEN_WIDTH-1:0] quot_r;
  logic [NUM_WIDTH-1:0]        num_mag;
  logic [DEN_WIDTH-1:0]        den_mag;
  logic [NW-1:0]               lim;
  logic [NW-1:0]               q_clamp;
  logic [DEN_WIDTH-1:0]        q_low;

  assign num_mag = i_num[NUM_WIDTH-1] ? NUM_WIDTH'(-i_num) : NUM_WIDTH'(i_num);
  assign den_mag = i_den[DEN_WIDTH-1] ? DEN_WIDTH'(-i_den) : DEN_WIDTH'(i_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_r[0]   <= {num_mag, {FRAC_BITS{1'b0}}};
    q_r[0]   <= '0;
    rem_r[0] <= '0;
    den_r[0] <= den_mag;
    neg_r[0] <= i_num[NUM_WIDTH-1] ^ i_den[DEN_WIDTH-1];
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [DEN_WIDTH:0] rem_sh;
    logic [DEN_WIDTH:0] rem_dif;
    logic               ge;

    assign rem_sh  = {rem_r[k-1], a_r[k-1][NW-1]};
    assign rem_dif = rem_sh - {1'b0, den_r[k-1]};
    assign ge      = rem_sh >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      a_r[k]   <= {a_r[k-1][NW-2:0], 1'b0};
      q_r[k]   <= {q_r[k-1][NW-2:0], ge};
      rem_r[k] <= ge ? rem_dif[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
      den_r[k] <= den_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
  end

  // Clamp to the signed output range
  assign lim     = neg_r[NW] ? (NW'(1) << (DEN_WIDTH - 1))
                             : ((NW'(1) << (DEN_WIDTH - 1)) - NW'(1));
  assign q_clamp = (q_r[NW] > lim) ? lim : q_r[NW];
  assign q_low   = q_clamp[DEN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= neg_r[NW] ? DEN_WIDTH'(-q_low) : DEN_WIDTH'(q_low);
  end

  assign o_valid = out_valid_r;
  assign o_quot  = quot_r;

endmodule
